/* rtl/spq_pkg.sv */
// shared types and constants of the sorted array priority queue
package spq_pkg;

  localparam int DEFAULT_DEPTH = 64;

  // result codes of a finished request
  typedef enum logic [1:0] {
    CODE_INSERTED = 2'd0,
    CODE_FULL     = 2'd1,
    CODE_SERVED   = 2'd2,
    CODE_EMPTY    = 2'd3
  } result_code_t;

  // request types
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  // one stored record
  typedef struct packed {
    logic [3:0]  urgency;
    logic [7:0]  age;
    logic [9:0]  weight;
    logic [15:0] tag;
  } rec_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic ins;
    logic deq;
    rec_t rec;
  } cmd_t;

endpackage

/* rtl/sorted_array_priority_queue.sv */
// top level of the sorted array priority queue
//
// bounded priority queue held as a row of QUEUE_DEPTH cells kept sorted by
// urgency, lowest value at the head, equal urgencies in arrival order. a
// request word is taken at every clock edge where start is high and busy is
// low; busy stays low, so one request is taken per cycle, back to back. the
// row shifts in the cycle of the request (right from the insertion point
// on to open a gap on insert, all of it left to drop the head on dequeue),
// and its result word shows on the result ports in the next cycle,
// marked by done for exactly one cycle. the receiver cannot stall: a result
// word that is not taken in that cycle is gone. an insert into a full queue
// returns the full code and leaves the queue unchanged; a dequeue on an
// empty queue returns the empty code with zero fields. record fields are
// zero on every result but a served dequeue. no clearing pass after reset.
module sorted_array_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [3:0]  urgency,
  input  logic [7:0]  age_years,
  input  logic [9:0]  weight_value,
  input  logic [15:0] record_tag,
  output logic        done,
  output logic [1:0]  result_code,
  output logic [3:0]  out_urgency,
  output logic [7:0]  out_age,
  output logic [9:0]  out_weight,
  output logic [15:0] out_tag
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             accept;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] count;
  cmd_t             cmd;
  rec_t             cell_rec  [QUEUE_DEPTH];
  logic             cell_move [QUEUE_DEPTH];

  // every cycle is free for a new request word
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;

  // shift commands only for requests that change the queue
  assign cmd.ins         = accept && (req_type == REQ_INSERT) && !full;
  assign cmd.deq         = accept && (req_type == REQ_DEQUEUE) && !empty;
  assign cmd.rec.urgency = urgency;
  assign cmd.rec.age     = age_years;
  assign cmd.rec.weight  = weight_value;
  assign cmd.rec.tag     = record_tag;

  // the cell row; left is toward the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    rec_t left_rec;
    logic left_move;
    rec_t right_rec;

    if (i == 0) begin : g_head
      assign left_rec  = cmd.rec;
      assign left_move = 1'b0;
    end else begin : g_body
      assign left_rec  = cell_rec[i-1];
      assign left_move = cell_move[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      // the tail slot is empty after a dequeue, its content is never read
      assign right_rec = cell_rec[i];
    end else begin : g_inner
      assign right_rec = cell_rec[i+1];
    end

    spq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .count     (count),
      .cmd       (cmd),
      .left_rec  (left_rec),
      .left_move (left_move),
      .right_rec (right_rec),
      .move      (cell_move[i]),
      .rec       (cell_rec[i])
    );
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins) begin
      count <= count + CNT_W'(1);
    end else if (cmd.deq) begin
      count <= count - CNT_W'(1);
    end
  end

  // result word register, shown for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_urgency <= '0;
      out_age     <= '0;
      out_weight  <= '0;
      out_tag     <= '0;
      if (req_type == REQ_INSERT) begin
        result_code <= full ? CODE_FULL : CODE_INSERTED;
      end else if (empty) begin
        result_code <= CODE_EMPTY;
      end else begin
        // head record leaves the row
        result_code <= CODE_SERVED;
        out_urgency <= cell_rec[0].urgency;
        out_age     <= cell_rec[0].age;
        out_weight  <= cell_rec[0].weight;
        out_tag     <= cell_rec[0].tag;
      end
    end
  end

endmodule

/* rtl/spq_cell.sv */
// one slot of the sorted record row
module spq_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic          clk,
  input  logic [CNT_W-1:0] count,
  input  spq_pkg::cmd_t cmd,
  input  spq_pkg::rec_t left_rec,
  input  logic          left_move,
  input  spq_pkg::rec_t right_rec,
  output logic          move,
  output spq_pkg::rec_t rec
);
  import spq_pkg::*;

  logic occupied;

  // slot in use, entries sit packed at the low end of the row
  assign occupied = CNT_W'(INDEX) < count;

  // slot must change on insert: empty or holds a later key
  assign move = !occupied || (rec.urgency > cmd.rec.urgency);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (move) begin
        rec <= left_move ? left_rec : cmd.rec;
      end
    end else if (cmd.deq) begin
      rec <= right_rec;
    end
  end

endmodule

/* rtl/spq_checker.sv */
// port level checks of the sorted array priority queue and their binding
module spq_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  result_code,
  input logic [3:0]  out_urgency,
  input logic [7:0]  out_age,
  input logic [9:0]  out_weight,
  input logic [15:0] out_tag
);
  import spq_pkg::*;

  // every taken request word gives a result word in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("request taken without a result word");

  // no result word without a request taken in the cycle before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) && $past(!rst)))
    else $error("result word without a request");

  // record fields are zero unless a record was served
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (result_code != CODE_SERVED)) |->
      (out_urgency == '0 && out_age == '0 && out_weight == '0 && out_tag == '0))
    else $error("nonzero record fields on a result that serves nothing");

  // a full report never comes right after reset
  a_full_after_result: assert property (@(posedge clk) disable iff (rst)
    (done && result_code == CODE_FULL) |-> $past(!rst, 2))
    else $error("full report right after reset");

endmodule

bind sorted_array_priority_queue spq_checker u_spq_checker (.*);
